>>> rtl/pth_pkg.sv
// Package: shared types, codes and hash constants of the pointer tracking table.
`timescale 1ns / 1ps
package pth_pkg;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam logic [47:0] BYTES_MAX  = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_TRACK   = 2'd0;
    localparam logic [1:0] OP_UNTRACK = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_MIN_SIZE = 2'd1;
    localparam logic [1:0] REG_MAX_LIVE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_HASH_X,
        S_HASH_M,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_SUB,
        S_ADD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic hash_xor;   // fold the next address byte into the hash
        logic hash_mul;   // multiply the hash by the prime (one partial step)
        logic slot_home;  // set probe index to the home slot
        logic slot_next;  // advance probe index
        logic mem_read;   // read probe slot
        logic wipe_step;  // write zero to wipe index, advance it
        logic ins_write;  // write new record at probe slot
        logic upd_write;  // write new size at probe slot
        logic del_write;  // empty probe slot
        logic bytes_sub;  // subtract operand from byte sum
        logic bytes_add;  // add operand to byte sum
        logic sel_old;    // subtract operand: old size (else item size)
        logic ins_count;  // bump serial, live count, inserts
        logic del_count;  // drop live count, bump removals
        logic clr_totals; // clear counters and byte sum
        logic set_status; // latch status code
        logic [2:0] status;
        logic ser_out;    // report serial of inserted record
        logic out_valid;  // present result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic addr_zero;
        logic size_small;
        logic at_limit;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic hash_done;
        logic mul_done;
        logic wipe_done;
        logic out_taken;
    } t_stat;

endpackage

>>> rtl/pointer_tracking_hash_table.sv
// Top level of the pointer tracking table: configuration registers and wiring.
`timescale 1ns / 1ps
// Usage.
// Input channel (i_valid/o_ready) carries one item: op, address, alloc_size,
// allocator_kind and time_stamp. Output channel (o_valid/i_ready) returns
// exactly one result item per input item: status, serial and the totals.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// Query, ignored and refused items go from the first state after the load
// straight to the result. Track and untrack hash the 8 address bytes with
// one xor and a two-step multiply each, then probe the slot memory with a
// read, a wait and a check state per slot visited; an insert or size update
// also passes through a byte-sum state before the result.
// Clear sweeps the slot memory one slot a cycle and then reports.
// One item is in flight at a time; o_ready is high only when idle, so the next
// item is taken in the cycle after the result is delivered at the earliest.
// After reset the same sweep runs before the first item is taken. A result
// holds on the outputs while i_ready is low, and no new item is taken until
// it is delivered.
module pointer_tracking_hash_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_address,
    input  logic [31:0] i_alloc_size,
    input  logic [1:0]  i_allocator_kind,
    input  logic [31:0] i_time_stamp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_record_serial,
    output logic [9:0]  o_live_count,
    output logic [47:0] o_live_bytes,
    output logic [63:0] o_total_tracked,
    output logic [63:0] o_total_released,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pth_pkg::*;

    logic        r_enable;
    logic [31:0] r_min_size;
    logic [9:0]  r_max_live;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_min_size <= '0;
            r_max_live <= 10'd1023;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_MIN_SIZE: r_min_size <= i_cfg_data;
                REG_MAX_LIVE: r_max_live <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    pth_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_enable (r_enable),
        .i_stat   (w_stat),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    pth_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_out_ready      (i_ready),
        .i_min_size       (r_min_size),
        .i_max_live       (r_max_live),
        .i_op             (i_op),
        .i_address        (i_address),
        .i_alloc_size     (i_alloc_size),
        .i_allocator_kind (i_allocator_kind),
        .i_time_stamp     (i_time_stamp),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_record_serial  (o_record_serial),
        .o_live_count     (o_live_count),
        .o_live_bytes     (o_live_bytes),
        .o_total_tracked  (o_total_tracked),
        .o_total_released (o_total_released)
    );

    assign o_valid = w_cmd.out_valid;

endmodule

>>> rtl/pth_ctrl.sv
// Controller state machine of the pointer tracking table.
`timescale 1ns / 1ps
module pth_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_enable,
    input  pth_pkg::t_stat i_stat,
    output logic           o_ready,
    output pth_pkg::t_cmd  o_cmd
);
    import pth_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_WIPE: begin
                o_cmd.wipe_step = 1'b1;
                if (i_stat.wipe_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH_X;
                end
            end
            S_HASH_X: begin
                case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.clr_totals = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DONE;
                        n_state          = S_WIPE;
                    end
                    OP_QUERY: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DONE;
                        n_state          = S_OUT;
                    end
                    OP_TRACK: begin
                        if (i_stat.addr_zero || !i_enable || i_stat.size_small) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_IGNORED;
                            n_state          = S_OUT;
                        end else if (i_stat.at_limit) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_DONE;
                            n_state          = S_OUT;
                        end else begin
                            o_cmd.hash_xor = 1'b1;
                            n_state        = S_HASH_M;
                        end
                    end
                    default: begin
                        if (i_stat.addr_zero || !i_enable) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_IGNORED;
                            n_state          = S_OUT;
                        end else begin
                            o_cmd.hash_xor = 1'b1;
                            n_state        = S_HASH_M;
                        end
                    end
                endcase
            end
            S_HASH_M: begin
                o_cmd.hash_mul = 1'b1;
                if (i_stat.mul_done) begin
                    if (i_stat.hash_done) begin
                        n_state = S_READ;
                        o_cmd.slot_home = 1'b1;
                    end else begin
                        n_state = S_HASH_X;
                    end
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.op == OP_TRACK) begin
                    if (i_stat.slot_match) begin
                        o_cmd.upd_write = 1'b1;
                        o_cmd.bytes_sub = 1'b1;
                        o_cmd.sel_old   = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status    = ST_UPDATED;
                        n_state         = S_ADD;
                    end else if (i_stat.slot_empty) begin
                        o_cmd.ins_write  = 1'b1;
                        o_cmd.ins_count  = 1'b1;
                        o_cmd.ser_out    = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_INSERTED;
                        n_state          = S_ADD;
                    end else if (i_stat.probe_last) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DONE;
                        n_state          = S_OUT;
                    end else begin
                        o_cmd.slot_next = 1'b1;
                        n_state         = S_READ;
                    end
                end else begin
                    if (i_stat.slot_empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOTFOUND;
                        n_state          = S_OUT;
                    end else if (i_stat.slot_match) begin
                        o_cmd.del_write  = 1'b1;
                        o_cmd.bytes_sub  = 1'b1;
                        o_cmd.sel_old    = 1'b1;
                        o_cmd.del_count  = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_REMOVED;
                        n_state          = S_OUT;
                    end else if (i_stat.probe_last) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOTFOUND;
                        n_state          = S_OUT;
                    end else begin
                        o_cmd.slot_next = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            S_SUB: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.bytes_add = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_valid = 1'b1;
                if (i_stat.out_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A clear runs the wipe sweep and then reports.
        if (r_state == S_WIPE && i_stat.wipe_done && i_stat.op == OP_CLEAR
                && !i_stat.out_taken) begin
            n_state = S_OUT;
        end
    end

endmodule

>>> rtl/pth_dp.sv
// Datapath of the pointer tracking table: hash unit, slot memory and counters.
`timescale 1ns / 1ps
module pth_dp #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pth_pkg::t_cmd          i_cmd,
    input  logic                   i_out_ready,
    input  logic [31:0]            i_min_size,
    input  logic [9:0]             i_max_live,
    input  logic [1:0]             i_op,
    input  logic [63:0]            i_address,
    input  logic [31:0]            i_alloc_size,
    input  logic [1:0]             i_allocator_kind,
    input  logic [31:0]            i_time_stamp,
    output pth_pkg::t_stat         o_stat,
    output logic [2:0]             o_status,
    output logic [63:0]            o_record_serial,
    output logic [9:0]             o_live_count,
    output logic [47:0]            o_live_bytes,
    output logic [63:0]            o_total_tracked,
    output logic [63:0]            o_total_released
);
    import pth_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);

    // Slot memories.
    logic [63:0] m_addr   [TABLE_SLOTS];
    logic [31:0] m_size   [TABLE_SLOTS];
    logic [1:0]  m_kind   [TABLE_SLOTS];
    logic [63:0] m_serial [TABLE_SLOTS];
    logic [31:0] m_time   [TABLE_SLOTS];

    logic [1:0]  r_op;
    logic [63:0] r_addr;
    logic [31:0] r_size;
    logic [1:0]  r_kind;
    logic [31:0] r_time;
    logic [63:0] r_hash;
    logic [2:0]  r_byte;
    logic        r_last_byte;
    logic [1:0]  r_mstep;
    logic [63:0] r_acc;
    logic [IW-1:0] r_idx;
    logic [IW:0]   r_probes;
    logic [IW:0]   r_wipe;
    logic [63:0] r_rd_addr;
    logic [31:0] r_rd_size;
    logic [63:0] r_serial_next;
    logic [9:0]  r_live;
    logic [47:0] r_bytes;
    logic [63:0] r_ins;
    logic [63:0] r_del;
    logic [2:0]  r_status;
    logic [63:0] r_ser_out;

    logic [7:0]  w_byte;
    logic [63:0] w_mul_part;
    logic [31:0] w_sub_op;
    logic [47:0] w_sub_ext;
    logic [47:0] w_add_ext;
    logic [47:0] w_room;

    assign w_byte = r_addr[{r_byte, 3'b000} +: 8];

    // Hash multiply split into two partial steps: a 64x9 product and a shifted add.
    // h*P mod 2^64 with P = 2^40 + 0x1b3:
    // step0: acc = h * 0x1b3 ; step1: acc += h[23:0] << 40.
    always_comb begin
        case (r_mstep)
            2'd0:    w_mul_part = r_hash * 64'(FNV_PRIME[8:0]);
            default: w_mul_part = r_acc + {r_hash[23:0], 40'd0};
        endcase
    end

    assign w_sub_op  = i_cmd.sel_old ? r_rd_size : r_size;
    assign w_sub_ext = {16'd0, w_sub_op};
    assign w_add_ext = {16'd0, r_size};
    assign w_room    = BYTES_MAX - r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe        <= '0;
            r_serial_next <= 64'd1;
            r_live        <= '0;
            r_bytes       <= '0;
            r_ins         <= '0;
            r_del         <= '0;
            r_mstep       <= '0;
            r_op          <= OP_QUERY;
        end else begin
            if (i_cmd.load) begin
                r_op        <= i_op;
                r_addr      <= i_address;
                r_size      <= i_alloc_size;
                r_kind      <= i_allocator_kind;
                r_time      <= i_time_stamp;
                r_hash      <= FNV_OFFSET;
                r_byte      <= '0;
                r_last_byte <= 1'b0;
                r_mstep     <= '0;
                r_wipe      <= '0;
            end
            if (i_cmd.hash_xor) begin
                r_hash      <= r_hash ^ {56'd0, w_byte};
                r_last_byte <= (r_byte == 3'd7);
                r_byte      <= r_byte + 3'd1;
            end
            if (i_cmd.hash_mul) begin
                if (r_mstep == 2'd0) begin
                    r_acc   <= w_mul_part;
                    r_mstep <= 2'd1;
                end else begin
                    r_hash  <= w_mul_part;
                    r_mstep <= 2'd0;
                end
            end
            if (i_cmd.slot_home) begin
                r_idx    <= w_mul_part[IW-1:0];
                r_probes <= '0;
            end
            if (i_cmd.slot_next) begin
                r_idx    <= r_idx + 1'b1;
                r_probes <= r_probes + 1'b1;
            end
            if (i_cmd.wipe_step && !r_wipe[IW]) begin
                r_wipe <= r_wipe + 1'b1;
            end
            if (i_cmd.ins_count) begin
                r_ser_out     <= r_serial_next;
                r_serial_next <= r_serial_next + 64'd1;
                r_live        <= r_live + 10'd1;
                r_ins         <= r_ins + 64'd1;
            end else if (i_cmd.load) begin
                r_ser_out <= '0;
            end
            if (i_cmd.del_count) begin
                r_live <= r_live - 10'd1;
                r_del  <= r_del + 64'd1;
            end
            if (i_cmd.bytes_sub) begin
                r_bytes <= (w_sub_ext > r_bytes) ? 48'd0 : r_bytes - w_sub_ext;
            end
            if (i_cmd.bytes_add) begin
                r_bytes <= (w_add_ext > w_room) ? BYTES_MAX : r_bytes + w_add_ext;
            end
            if (i_cmd.clr_totals) begin
                r_live  <= '0;
                r_bytes <= '0;
                r_ins   <= '0;
                r_del   <= '0;
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
        end
    end

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wipe_step && !r_wipe[IW]) begin
            m_addr[r_wipe[IW-1:0]] <= '0;
            m_size[r_wipe[IW-1:0]] <= '0;
        end else if (i_cmd.ins_write) begin
            m_addr[r_idx]   <= r_addr;
            m_size[r_idx]   <= r_size;
            m_kind[r_idx]   <= r_kind;
            m_serial[r_idx] <= r_serial_next;
            m_time[r_idx]   <= r_time;
        end else if (i_cmd.upd_write) begin
            m_size[r_idx] <= r_size;
        end else if (i_cmd.del_write) begin
            m_addr[r_idx] <= '0;
            m_size[r_idx] <= '0;
        end
        if (i_cmd.mem_read) begin
            r_rd_addr <= m_addr[r_idx];
            r_rd_size <= m_size[r_idx];
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.addr_zero  = (r_addr == 64'd0);
        o_stat.size_small = (r_size < i_min_size);
        o_stat.at_limit   = (r_live >= i_max_live);
        o_stat.slot_empty = (r_rd_addr == 64'd0);
        o_stat.slot_match = (r_rd_addr == r_addr);
        o_stat.probe_last = (r_probes == (IW + 1)'(TABLE_SLOTS - 1));
        o_stat.hash_done  = r_last_byte;
        o_stat.mul_done   = (r_mstep == 2'd1);
        o_stat.wipe_done  = r_wipe[IW];
        o_stat.out_taken  = i_cmd.out_valid && i_out_ready;
    end

    assign o_status         = r_status;
    assign o_record_serial  = r_ser_out;
    assign o_live_count     = r_live;
    assign o_live_bytes     = r_bytes;
    assign o_total_tracked  = r_ins;
    assign o_total_released = r_del;

endmodule
